FILE: rtl/dtte_pkg.sv
package dtte_pkg;

  // first year of the count
  localparam int unsigned BASE_YEAR = 1970;

  localparam int unsigned YEAR_W = 14;   // up to 9999
  localparam int unsigned NUM_W  = 7;    // two-digit fields up to 99
  localparam int unsigned LEAP_W = 12;   // leap-day counts up to 2424
  localparam int unsigned CUM_W  = 9;    // days before a month, up to 334
  localparam int unsigned HMS_W  = 19;   // up to 99*3600 + 99*60 + 99
  localparam int unsigned DAYS_W = 22;
  localparam int unsigned SECS_W = 38;

  localparam int unsigned SECS_PER_DAY = 86400;

  // n / 100 as (n * 5243) >> 19, exact for every n below 43699
  localparam int unsigned DIV100_MUL = 5243;
  localparam int unsigned DIV100_SH  = 19;
  localparam int unsigned DIV100_W   = 27;

  // leap years in 1 .. BASE_YEAR - 1
  localparam int unsigned LEAPS_BASE = (BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100
                                     + (BASE_YEAR - 1) / 400;

  // days in the whole months before month m of a common year
  function automatic logic [CUM_W-1:0] days_before_month(input logic [3:0] m);
    logic [CUM_W-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/date_time_text_to_epoch_seconds_top.sv
// ascii date YYYYMMDD and time HHMMSS to seconds since jan 1 of the base year
// each request is registered in every stage in turn before it reaches the output
// throughput: one request per cycle unless the output stalls; each stage holds
// its own valid bit and moves on when the next stage is free, so bubbles close up
// reset: rst_ni low clears all stage valid bits at once; data registers keep
// whatever they hold and are ignored until their valid bit is set again
module date_time_text_to_epoch_seconds_top
  import dtte_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [111:0] s_axis_tdata_i,   // [63:0] date_chars, [111:64] time_chars
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [39:0]  m_axis_tdata_o,   // [37:0] epoch_seconds, [39:38] zero
  output logic         m_axis_tuser_o    // [0] bad_input
);

  // per-stage valid bits and advance enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || m_axis_tready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: split the 14 characters into digits, flag any non-digit,
  // and assemble the decimal fields
  // ---------------------------------------------------------------------------
  logic [7:0]        chr [14];
  logic [3:0]        dig [14];
  logic              nondig;
  logic [YEAR_W-1:0] year_d;
  logic [NUM_W-1:0]  mon_d, day_d, hr_d, mi_d, se_d;

  always_comb begin
    nondig = 1'b0;
    for (int k = 0; k < 8; k++) begin
      chr[k] = s_axis_tdata_i[56 - 8*k +: 8];
    end
    for (int k = 0; k < 6; k++) begin
      chr[8 + k] = s_axis_tdata_i[64 + 40 - 8*k +: 8];
    end
    for (int k = 0; k < 14; k++) begin
      dig[k] = chr[k][3:0];
      if (!(chr[k] inside {[8'h30:8'h39]})) begin
        nondig = 1'b1;
      end
    end
    year_d = YEAR_W'(dig[0]) * 14'd1000 + YEAR_W'(dig[1]) * 14'd100
           + YEAR_W'(dig[2]) * 14'd10 + YEAR_W'(dig[3]);
    mon_d  = NUM_W'(dig[4])  * 7'd10 + NUM_W'(dig[5]);
    day_d  = NUM_W'(dig[6])  * 7'd10 + NUM_W'(dig[7]);
    hr_d   = NUM_W'(dig[8])  * 7'd10 + NUM_W'(dig[9]);
    mi_d   = NUM_W'(dig[10]) * 7'd10 + NUM_W'(dig[11]);
    se_d   = NUM_W'(dig[12]) * 7'd10 + NUM_W'(dig[13]);
  end

  logic [YEAR_W-1:0] year1_q;
  logic [NUM_W-1:0]  mon1_q, day1_q, hr1_q, mi1_q, se1_q;
  logic              bad1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      year1_q <= year_d;
      mon1_q  <= mon_d;
      day1_q  <= day_d;
      hr1_q   <= hr_d;
      mi1_q   <= mi_d;
      se1_q   <= se_d;
      bad1_q  <= nondig;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: range checks, divide by 100 through the reciprocal, days of the
  // whole years, days before the month, and the time of day in seconds
  // ---------------------------------------------------------------------------
  logic [YEAR_W-1:0]   yprev;
  logic [DIV100_W-1:0] q100p_prod, q100y_prod;
  logic                bad_d2;

  assign yprev      = year1_q - 14'd1;
  assign q100p_prod = DIV100_W'(yprev)   * DIV100_W'(DIV100_MUL);
  assign q100y_prod = DIV100_W'(year1_q) * DIV100_W'(DIV100_MUL);
  assign bad_d2     = bad1_q || (year1_q < YEAR_W'(BASE_YEAR)) || (mon1_q == 7'd0)
                   || (mon1_q > 7'd12) || (day1_q == 7'd0);

  logic [YEAR_W-1:0] year2_q;
  logic [LEAP_W-1:0] yq4_2_q;      // (year - 1) / 4
  logic [NUM_W-1:0]  q100p2_q;     // (year - 1) / 100
  logic [NUM_W-1:0]  q100y2_q;     // year / 100
  logic [DAYS_W-1:0] ydays2_q;     // 365 per whole year since the base
  logic [CUM_W-1:0]  cum2_q;
  logic              past_feb2_q;
  logic [NUM_W-1:0]  dm1_2_q;      // day - 1
  logic [HMS_W-1:0]  hms2_q;
  logic              bad2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      year2_q     <= year1_q;
      yq4_2_q     <= yprev[YEAR_W-1:2];
      q100p2_q    <= q100p_prod[DIV100_SH +: NUM_W];
      q100y2_q    <= q100y_prod[DIV100_SH +: NUM_W];
      ydays2_q    <= DAYS_W'(year1_q - YEAR_W'(BASE_YEAR)) * 22'd365;
      cum2_q      <= days_before_month(mon1_q[3:0]);
      past_feb2_q <= (mon1_q > 7'd2);
      dm1_2_q     <= day1_q - 7'd1;
      hms2_q      <= HMS_W'(hr1_q) * 19'd3600 + HMS_W'(mi1_q) * 19'd60 + HMS_W'(se1_q);
      bad2_q      <= bad_d2;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: leap days since the base, leap flag of this year, day count
  // ---------------------------------------------------------------------------
  logic              cent;
  logic              leap;
  logic [LEAP_W-1:0] leaps;

  // a century year is a leap year only when year / 100 is a multiple of four
  assign cent  = (year2_q == YEAR_W'(q100y2_q) * 14'd100);
  assign leap  = cent ? (q100y2_q[1:0] == 2'd0) : (year2_q[1:0] == 2'd0);
  assign leaps = yq4_2_q - LEAP_W'(q100p2_q) + LEAP_W'(q100p2_q[NUM_W-1:2])
               - LEAP_W'(LEAPS_BASE);

  logic [DAYS_W-1:0] days3_q;
  logic [HMS_W-1:0]  hms3_q;
  logic              bad3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      days3_q <= ydays2_q + DAYS_W'(leaps) + DAYS_W'(cum2_q)
               + DAYS_W'(leap && past_feb2_q) + DAYS_W'(dm1_2_q);
      hms3_q  <= hms2_q;
      bad3_q  <= bad2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: days to seconds, kept modulo 2^38
  // ---------------------------------------------------------------------------
  logic [SECS_W:0] dsec_prod;

  assign dsec_prod = (SECS_W + 1)'(days3_q) * (SECS_W + 1)'(SECS_PER_DAY);

  logic [SECS_W-1:0] dsec4_q;
  logic [HMS_W-1:0]  hms4_q;
  logic              bad4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      dsec4_q <= dsec_prod[SECS_W-1:0];
      hms4_q  <= hms3_q;
      bad4_q  <= bad3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: add the time of day; a rejected request gives zero seconds
  // ---------------------------------------------------------------------------
  logic [SECS_W-1:0] secs5_q;
  logic              bad5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      secs5_q <= bad4_q ? '0 : dsec4_q + SECS_W'(hms4_q);
      bad5_q  <= bad4_q;
    end
  end

  assign m_axis_tvalid_o = v5_q;
  assign m_axis_tdata_o  = {2'b00, secs5_q};
  assign m_axis_tuser_o  = bad5_q;

`ifndef SYNTHESIS
  // a rejected request always shows zero seconds
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[37:0] == 38'd0)
    else $error("bad request with nonzero seconds");

  // input side only stalls when the output holds a result that is not taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // a good request past the checks has a month in range and a nonzero day
  a_fields_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !bad2_q |-> past_feb2_q == (cum2_q > 9'd31) && cum2_q <= 9'd334
                        && dm1_2_q < 7'd99)
    else $error("accepted fields out of range");

  // a good year is never below the base, so its year offset stays small
  a_year_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !bad2_q |-> year2_q >= YEAR_W'(BASE_YEAR) && ydays2_q <= 22'd3649635)
    else $error("accepted year below base");
`endif

endmodule

FILE: sim/tb_date_time_text_to_epoch_seconds_top.sv
module tb_date_time_text_to_epoch_seconds_top
  import dtte_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  CHAR_ZERO      = 8'h30;
  localparam logic [7:0]  CHAR_NINE      = 8'h39;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned ITEMS_PER_PHASE = 170;
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                              31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [SECS_W-1:0] secs;
    logic              bad;
  } epoch_result_t;

  // expected conversions, oldest first
  class epoch_scoreboard;
    epoch_result_t expected_epochs[$];
    int unsigned   errors = 0;

    static function longint unsigned leap_years_through(longint unsigned n);
      return n / 4 - n / 100 + n / 400;
    endfunction

    static function bit is_leap(longint unsigned y);
      return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    // decode the fourteen characters and count seconds since the base year
    static function epoch_result_t seconds_from_text(logic [63:0] date_txt,
                                                     logic [47:0] time_txt);
      logic [111:0]      txt;
      longint unsigned   num [14];
      longint unsigned   yr, mo, dy, hh, mi, ss, days, total;
      epoch_result_t     res;
      txt      = {date_txt, time_txt};
      res.bad  = 1'b0;
      res.secs = '0;
      for (int k = 0; k < 14; k++) begin
        logic [7:0] ch;
        ch = txt[111-8*k -: 8];
        if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
          res.bad = 1'b1;
          num[k]  = 0;
        end else begin
          num[k] = ch - CHAR_ZERO;
        end
      end
      yr = num[0] * 1000 + num[1] * 100 + num[2] * 10 + num[3];
      mo = num[4] * 10 + num[5];
      dy = num[6] * 10 + num[7];
      hh = num[8] * 10 + num[9];
      mi = num[10] * 10 + num[11];
      ss = num[12] * 10 + num[13];
      if (yr < BASE_YEAR || mo < 1 || mo > 12 || dy == 0) res.bad = 1'b1;
      if (!res.bad) begin
        days = (yr - BASE_YEAR) * 365
             + leap_years_through(yr - 1) - leap_years_through(BASE_YEAR - 1);
        for (int m = 1; m < mo; m++) begin
          days += MONTH_DAYS[m-1];
          if (m == 2 && is_leap(yr)) days += 1;
        end
        days += dy - 1;
        total    = ((days * 24 + hh) * 60 + mi) * 60 + ss;
        res.secs = total[SECS_W-1:0];
      end
      return res;
    endfunction

    function void note_request(logic [63:0] date_txt, logic [47:0] time_txt);
      expected_epochs.push_back(seconds_from_text(date_txt, time_txt));
    endfunction

    function void check_result(logic [SECS_W-1:0] secs, logic bad);
      epoch_result_t want;
      if (expected_epochs.size() == 0) begin
        $error("result with no request pending: epoch_seconds %0d bad_input %0b", secs, bad);
        errors++;
        return;
      end
      want = expected_epochs.pop_front();
      if (secs !== want.secs) begin
        $error("epoch_seconds: expected %0d, actual %0d", want.secs, secs);
        errors++;
      end
      if (bad !== want.bad) begin
        $error("bad_input: expected %0b, actual %0b", want.bad, bad);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_epochs.size();
    endfunction
  endclass

  logic         clk_i  = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic [111:0] s_data  = '0;
  logic         m_ready = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [39:0]  m_axis_tdata_o;   // [37:0] epoch_seconds, [39:38] zero
  logic         m_axis_tuser_o;   // [0] bad_input

  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  bit           hold_start     = 1'b0;
  int unsigned  hold_left      = 0;
  int unsigned  quiet_cycles   = 0;

  epoch_scoreboard sb = new();

  date_time_text_to_epoch_seconds_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when asked for one
  always @(negedge clk_i) begin
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      m_ready = 1'b0;
      hold_left--;
    end else begin
      m_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // both handshakes sampled at the rising edge, plus the no-progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) sb.note_request(s_data[63:0], s_data[111:64]);
      if (m_axis_tvalid_o && m_ready) sb.check_result(m_axis_tdata_o[SECS_W-1:0], m_axis_tuser_o);
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // n ascii digits of v, most significant digit in the highest byte
  function automatic logic [63:0] ascii_digits(int unsigned v, int unsigned n);
    logic [63:0] txt;
    txt = '0;
    for (int i = 0; i < n; i++) begin
      txt[8*i +: 8] = CHAR_ZERO + 8'(v % 10);
      v = v / 10;
    end
    return txt;
  endfunction

  function automatic logic [63:0] date_text(int unsigned yr, int unsigned mo, int unsigned dy);
    return (ascii_digits(yr, 4) << 32) | (ascii_digits(mo, 2) << 16) | ascii_digits(dy, 2);
  endfunction

  function automatic logic [47:0] time_text(int unsigned hh, int unsigned mi, int unsigned ss);
    logic [63:0] txt;
    txt = (ascii_digits(hh, 2) << 32) | (ascii_digits(mi, 2) << 16) | ascii_digits(ss, 2);
    return txt[47:0];
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [63:0] date_txt, input logic [47:0] time_txt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = {time_txt, date_txt};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // mostly plausible date-time pairs, the rest out of range or raw noise
  task automatic random_request();
    logic [63:0] d;
    logic [47:0] t;
    int unsigned roll, pos;
    int unsigned yr, mo, dy;
    roll = $urandom_range(99);
    yr   = ($urandom_range(9) < 8) ? $urandom_range(2200, BASE_YEAR)
                                   : $urandom_range(9999, BASE_YEAR);
    mo   = $urandom_range(12, 1);
    dy   = ($urandom_range(9) == 0) ? $urandom_range(99, 1) : $urandom_range(31, 1);
    if ($urandom_range(9) == 0) begin
      t = time_text($urandom_range(99), $urandom_range(99), $urandom_range(99));
    end else begin
      t = time_text($urandom_range(23), $urandom_range(59), $urandom_range(59));
    end
    if (roll >= 75 && roll < 85) begin
      // out-of-range year, month or day
      case ($urandom_range(3))
        0:       yr = $urandom_range(BASE_YEAR - 1);
        1:       mo = 0;
        2:       mo = $urandom_range(99, 13);
        default: dy = 0;
      endcase
    end
    d = date_text(yr, mo, dy);
    if (roll >= 85 && roll < 93) begin
      // one byte replaced by anything at all
      pos = $urandom_range(13);
      if (pos < 8) d[8*pos +: 8] = 8'($urandom);
      else         t[8*(pos-8) +: 8] = 8'($urandom);
    end else if (roll >= 93) begin
      d = {$urandom, $urandom};
      t = {16'($urandom), $urandom};
    end
    send_request(d, t);
  endtask

  initial begin
    int unsigned idle_by_phase  [4] = '{0, 50, 0, 35};
    int unsigned stall_by_phase [4] = '{0, 0, 50, 35};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, leap rules, every rejection
    send_request(date_text(1970, 1, 1), time_text(0, 0, 0));
    send_request(date_text(1970, 1, 1), time_text(0, 0, 1));
    send_request(date_text(1970, 12, 31), time_text(23, 59, 59));
    send_request(date_text(9999, 12, 31), time_text(23, 59, 59));
    send_request(date_text(9999, 12, 99), time_text(99, 99, 99));
    send_request(date_text(2024, 5, 17), time_text(99, 99, 99));
    send_request(date_text(2000, 2, 29), time_text(12, 0, 0));
    send_request(date_text(2000, 3, 1), time_text(0, 0, 0));
    send_request(date_text(2100, 2, 29), time_text(0, 0, 0));
    send_request(date_text(2100, 3, 1), time_text(0, 0, 0));
    send_request(date_text(2024, 3, 1), time_text(0, 0, 0));
    send_request(date_text(2023, 2, 31), time_text(6, 30, 0));
    send_request(date_text(1969, 12, 31), time_text(23, 59, 59));
    send_request(date_text(0, 1, 1), time_text(0, 0, 0));
    send_request(date_text(2024, 0, 10), time_text(0, 0, 0));
    send_request(date_text(2024, 13, 1), time_text(0, 0, 0));
    send_request(date_text(2024, 1, 0), time_text(0, 0, 0));
    // characters just outside the digit range: '/' in the year, ':' in the minutes
    send_request(date_text(2024, 1, 1) ^ 64'h0000_001B_0000_0000, time_text(1, 2, 3));
    send_request(date_text(2024, 1, 1), time_text(1, 2, 3) ^ 48'h0000_0008_0000);
    send_request(64'h3939_3939_3939_3939, 48'h3939_3939_3939);
    send_request('0, '0);
    send_request('1, '1);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      // back-pressure burst: receiver holds off while requests keep coming
      if (p == 0) hold_start = 1'b1;
      repeat (ITEMS_PER_PHASE) random_request();
    end
    s_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
